/* src/vn2_pkg.sv */
// vn2_pkg: shared constants and types of the 2d value noise block
// used by vn2_ease and value_noise_2d; no dependencies
`default_nettype none

package vn2_pkg;

   // lattice hash multipliers
   localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
   localparam logic [31:0] HASH_MUL_Z   = 32'd668265263;
   localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

   // one in q1.16
   localparam logic [16:0] ONE_Q16 = 17'h1_0000;

   // load strobes of the two easing stages
   typedef struct packed {
      logic stage1;
      logic stage2;
   } ease_load_type;

endpackage

`default_nettype wire

/* src/value_noise_2d.sv */
// value_noise_2d: hashed-lattice 2d value noise with smoothstep bilinear blend
// depends on vn2_pkg and vn2_ease
//
//  channel | dir | payload (lsb first)                         | transaction
//  req     | in  | noise_seed, x_coord (q.FRAC), z_coord (q.FRAC) | one sample point
//  rsp     | out | noise_value (unsigned q0.32)                 | one noise sample
//
// eight register stages; while rsp_tready stays high a sample enters every clock
// and one result per clock is sustained on rsp_tvalid
// the stage chain covers weight easing, corner hash multiply,
// x blend products, z blend partial products and the final wide add
// reset clears the stage valid bits only; payload registers keep no reset
// each stage holds while its successor is full and stalled, bubbles collapse,
// so req_tready stays high whenever any stage is empty
`default_nettype none

module value_noise_2d #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // slave side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // noise_seed[31:0], x_coord[63:32], z_coord[95:64]
   // master side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // noise_value[31:0]
);
   import vn2_pkg::*;

   localparam int STAGES = 8;

   // ---------------------------------------------------------------- flow control
   logic [STAGES:1] vld_in, vld_ff;
   logic [STAGES:1] vld_prev;
   logic [STAGES:1] rdy;

   always_comb begin
      rdy[STAGES] = !vld_ff[STAGES] || rsp_tready;
      for (int i = STAGES - 1; i >= 1; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i + 1];
      end
   end

   assign vld_prev = {vld_ff[STAGES-1:1], req_tvalid};
   assign vld_in   = (rdy & vld_prev) | (~rdy & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = rdy[1];
   assign rsp_tvalid = vld_ff[STAGES];

   // ---------------------------------------------------------------- weights
   ease_load_type ease_load;
   logic [15:0]   wx_s2, wz_s2;

   assign ease_load.stage1 = rdy[1];
   assign ease_load.stage2 = rdy[2];

   vn2_ease #(.FRAC_BITS(FRAC_BITS)) u_ease_x (
      .clock  (clock),
      .load   (ease_load),
      .coord  (req_tdata[63:32]),
      .weight (wx_s2)
   );

   vn2_ease #(.FRAC_BITS(FRAC_BITS)) u_ease_z (
      .clock  (clock),
      .load   (ease_load),
      .coord  (req_tdata[95:64]),
      .weight (wz_s2)
   );

   // ---------------------------------------------------------------- stage 1
   // floor cell and its hash products
   logic signed [31:0] x_s, z_s;
   logic [31:0]        cell_x, cell_z;
   logic [31:0]        s1_seed_in, s1_seed_ff;
   logic [31:0]        s1_px_in, s1_px_ff;
   logic [31:0]        s1_pz_in, s1_pz_ff;

   always_comb begin
      x_s        = signed'(req_tdata[63:32]);
      z_s        = signed'(req_tdata[95:64]);
      cell_x     = 32'(x_s >>> FRAC_BITS);
      cell_z     = 32'(z_s >>> FRAC_BITS);
      s1_seed_in = req_tdata[31:0];
      s1_px_in   = cell_x * HASH_MUL_X;
      s1_pz_in   = cell_z * HASH_MUL_Z;
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_seed_ff <= s1_seed_in;
         s1_px_ff   <= s1_px_in;
         s1_pz_ff   <= s1_pz_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // corner words before the mix multiply; the +1 neighbor is the product plus
   // the multiplier, wrapping the same way as the cell index
   function automatic logic [31:0] pre_mix(input logic [31:0] seed,
                                           input logic [31:0] px,
                                           input logic [31:0] pz);
      logic [31:0] h;
      h = seed ^ px ^ pz;
      return h ^ (h >> 13);
   endfunction

   logic [31:0] px1, pz1;
   logic [31:0] s2_mix_in [4];
   logic [31:0] s2_mix_ff [4];

   always_comb begin
      px1          = s1_px_ff + HASH_MUL_X;
      pz1          = s1_pz_ff + HASH_MUL_Z;
      s2_mix_in[0] = pre_mix(s1_seed_ff, s1_px_ff, s1_pz_ff);   // (ix,   iz)
      s2_mix_in[1] = pre_mix(s1_seed_ff, px1,      s1_pz_ff);   // (ix+1, iz)
      s2_mix_in[2] = pre_mix(s1_seed_ff, s1_px_ff, pz1);        // (ix,   iz+1)
      s2_mix_in[3] = pre_mix(s1_seed_ff, px1,      pz1);        // (ix+1, iz+1)
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s2_mix_ff <= s2_mix_in;
      end
   end

   // ---------------------------------------------------------------- stage 3
   // mix multiply, complementary weights
   logic [31:0] s3_hash_in [4];
   logic [31:0] s3_hash_ff [4];
   logic [16:0] s3_wxl_in, s3_wxl_ff, s3_wxh_in, s3_wxh_ff;
   logic [16:0] s3_wzl_in, s3_wzl_ff, s3_wzh_in, s3_wzh_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         s3_hash_in[j] = s2_mix_ff[j] * HASH_MUL_MIX;
      end
      s3_wxh_in = {1'b0, wx_s2};
      s3_wxl_in = ONE_Q16 - s3_wxh_in;
      s3_wzh_in = {1'b0, wz_s2};
      s3_wzl_in = ONE_Q16 - s3_wzh_in;
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s3_hash_ff <= s3_hash_in;
         s3_wxl_ff  <= s3_wxl_in;
         s3_wxh_ff  <= s3_wxh_in;
         s3_wzl_ff  <= s3_wzl_in;
         s3_wzh_ff  <= s3_wzh_in;
      end
   end

   // ---------------------------------------------------------------- stage 4
   // final corner fold and x blend products (corner * weight < 2^48)
   logic [31:0] corner [4];
   logic [47:0] s4_prod_in [4];
   logic [47:0] s4_prod_ff [4];
   logic [16:0] s4_wzl_ff, s4_wzh_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         corner[j] = s3_hash_ff[j] ^ (s3_hash_ff[j] >> 16);
      end
      s4_prod_in[0] = 48'(corner[0]) * 48'(s3_wxl_ff);
      s4_prod_in[1] = 48'(corner[1]) * 48'(s3_wxh_ff);
      s4_prod_in[2] = 48'(corner[2]) * 48'(s3_wxl_ff);
      s4_prod_in[3] = 48'(corner[3]) * 48'(s3_wxh_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s4_prod_ff <= s4_prod_in;
         s4_wzl_ff  <= s3_wzl_ff;
         s4_wzh_ff  <= s3_wzh_ff;
      end
   end

   // ---------------------------------------------------------------- stage 5
   // top and bottom rows, exact; the weights sum to one so no carry out of 48 bits
   logic [47:0] s5_top_in, s5_top_ff, s5_bot_in, s5_bot_ff;
   logic [16:0] s5_wzl_ff, s5_wzh_ff;

   always_comb begin
      s5_top_in = s4_prod_ff[0] + s4_prod_ff[1];
      s5_bot_in = s4_prod_ff[2] + s4_prod_ff[3];
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         s5_top_ff <= s5_top_in;
         s5_bot_ff <= s5_bot_in;
         s5_wzl_ff <= s4_wzl_ff;
         s5_wzh_ff <= s4_wzh_ff;
      end
   end

   // ---------------------------------------------------------------- stage 6
   // z blend as 24-bit halves times the 17-bit weights
   logic [40:0] s6_top_hi_in, s6_top_hi_ff, s6_top_lo_in, s6_top_lo_ff;
   logic [40:0] s6_bot_hi_in, s6_bot_hi_ff, s6_bot_lo_in, s6_bot_lo_ff;

   always_comb begin
      s6_top_hi_in = 41'(s5_top_ff[47:24]) * 41'(s5_wzl_ff);
      s6_top_lo_in = 41'(s5_top_ff[23:0])  * 41'(s5_wzl_ff);
      s6_bot_hi_in = 41'(s5_bot_ff[47:24]) * 41'(s5_wzh_ff);
      s6_bot_lo_in = 41'(s5_bot_ff[23:0])  * 41'(s5_wzh_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         s6_top_hi_ff <= s6_top_hi_in;
         s6_top_lo_ff <= s6_top_lo_in;
         s6_bot_hi_ff <= s6_bot_hi_in;
         s6_bot_lo_ff <= s6_bot_lo_in;
      end
   end

   // ---------------------------------------------------------------- stage 7
   logic [41:0] s7_hi_in, s7_hi_ff, s7_lo_in, s7_lo_ff;

   always_comb begin
      s7_hi_in = 42'(s6_top_hi_ff) + 42'(s6_bot_hi_ff);
      s7_lo_in = 42'(s6_top_lo_ff) + 42'(s6_bot_lo_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[7]) begin
         s7_hi_ff <= s7_hi_in;
         s7_lo_ff <= s7_lo_in;
      end
   end

   // ---------------------------------------------------------------- stage 8
   // recombine halves, drop 32 fraction bits, clamp at all ones
   logic [66:0] blend_sum;
   logic [34:0] blend_int;
   logic [31:0] s8_value_in, s8_value_ff;

   always_comb begin
      blend_sum   = {1'b0, s7_hi_ff, 24'd0} + 67'(s7_lo_ff);
      blend_int   = blend_sum[66:32];
      s8_value_in = (|blend_int[34:32]) ? '1 : blend_int[31:0];
   end

   always_ff @(posedge clock) begin
      if (rdy[8]) begin
         s8_value_ff <= s8_value_in;
      end
   end

   assign rsp_tdata = s8_value_ff;

   // ---------------------------------------------------------------- checks
   // an accepted sample without a delivered one grows the occupancy by one
   a_fill_up : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !(rsp_tvalid && rsp_tready))
      |=> ($countones(vld_ff) == $past($countones(vld_ff)) + 1))
      else $error("stage occupancy did not grow on an accepted sample");

   // a delivered sample without a new one shrinks it by one
   a_drain : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !(req_tvalid && req_tready))
      |=> ($countones(vld_ff) == $past($countones(vld_ff)) - 1))
      else $error("stage occupancy did not shrink on a delivered sample");

   // any empty stage lets a new sample in
   a_no_false_stall : assert property (@(posedge clock) disable iff (reset)
      !(&vld_ff) |-> req_tready)
      else $error("input stalled with a bubble in the pipeline");

   // x and z weight pairs each sum to one
   a_weight_sum : assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> ((18'(s3_wxl_ff) + 18'(s3_wxh_ff) == 18'(ONE_Q16)) &&
                     (18'(s3_wzl_ff) + 18'(s3_wzh_ff) == 18'(ONE_Q16))))
      else $error("blend weights do not sum to one");

endmodule

`default_nettype wire

/* src/vn2_ease.sv */
// vn2_ease: two-stage smoothstep of the coordinate fraction into a q0.16 weight
// depends on vn2_pkg
`default_nettype none

module vn2_ease #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  vn2_pkg::ease_load_type load,
   input  logic [31:0]            coord,
   output logic [15:0]            weight
);
   import vn2_pkg::*;

   localparam logic [31:0] FRAC_MASK = 32'((64'd1 << FRAC_BITS) - 64'd1);
   localparam int          T_SHR     = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int          T_SHL     = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

   logic [15:0] frac_q16;
   logic [31:0] sq_in,   sq_ff;
   logic [17:0] poly_in, poly_ff;
   logic [49:0] cube;
   logic [15:0] weight_in, weight_ff;

   always_comb begin
      // fraction brought to q0.16
      frac_q16  = 16'(((coord & FRAC_MASK) >> T_SHR) << T_SHL);
      sq_in     = 32'(frac_q16) * 32'(frac_q16);
      poly_in   = 18'(3 * ONE_Q16) - {1'b0, frac_q16, 1'b0};
      cube      = 50'(sq_ff) * 50'(poly_ff);
      weight_in = cube[47:32];
   end

   always_ff @(posedge clock) begin
      if (load.stage1) begin
         sq_ff   <= sq_in;
         poly_ff <= poly_in;
      end
      if (load.stage2) begin
         weight_ff <= weight_in;
      end
   end

   assign weight = weight_ff;

endmodule

`default_nettype wire

/* tb/value_noise_2d_test.sv */
// value_noise_2d_test: self-checking bench for the 2d value noise block, which
// predicts every noise sample from seed and point and checks the result stream
// depends on value_noise_2d (and through it vn2_pkg); needs no files or arguments
`timescale 1ns / 100ps

module value_noise_2d_test;

   localparam int FRAC_BITS = 16;
   localparam int RUN_LIMIT = 200000;   // cycles before the run is declared hung
   localparam int TAIL_WAIT = 20;       // settle time after the last result

   // own copies of the lattice hash multipliers
   localparam logic [31:0] MUL_X   = 32'd374761393;
   localparam logic [31:0] MUL_Z   = 32'd668265263;
   localparam logic [31:0] MUL_MIX = 32'd1274126177;
   localparam logic [63:0] UNIT_Q16 = 64'd65536;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;   // noise_seed[31:0], x_coord[63:32], z_coord[95:64]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // noise_value[31:0]

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_len  = 0;
   int cycle_count   = 0;

   value_noise_2d #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // predicts noise samples and holds them in order until the block returns them
   class noise_scoreboard;
      logic [31:0] pending_noise[$];
      int          errors = 0;

      function logic [31:0] lattice_hash(logic [31:0] seed, logic [31:0] i, logic [31:0] k);
         logic [31:0] h;
         h = seed ^ (i * MUL_X) ^ (k * MUL_Z);
         h = (h ^ (h >> 13)) * MUL_MIX;
         return h ^ (h >> 16);
      endfunction

      // fraction brought to q0.16, then smoothstep t*t*(3-2t)
      function logic [63:0] eased_fraction(logic [31:0] coord);
         logic [31:0] frac;
         logic [63:0] t;
         frac = coord & ((32'd1 << FRAC_BITS) - 32'd1);
         if (FRAC_BITS >= 16)
            t = 64'(frac >> (FRAC_BITS >= 16 ? FRAC_BITS - 16 : 0));
         else
            t = 64'(frac) << (FRAC_BITS < 16 ? 16 - FRAC_BITS : 0);
         t = t & 64'hFFFF;
         return (t * t * (64'd3 * UNIT_Q16 - 64'd2 * t)) >> 32;
      endfunction

      function logic [31:0] noise_at(logic [31:0] seed, logic [31:0] x, logic [31:0] z);
         logic [31:0] ix, iz;
         logic [63:0] wx, wz, a, b, c, d, top, bot, mix;
         ix = 32'($signed(x) >>> FRAC_BITS);
         iz = 32'($signed(z) >>> FRAC_BITS);
         wx = eased_fraction(x);
         wz = eased_fraction(z);
         // corners past the top of the cell wrap modulo 2^32
         a = 64'(lattice_hash(seed, ix, iz));
         b = 64'(lattice_hash(seed, ix + 32'd1, iz));
         c = 64'(lattice_hash(seed, ix, iz + 32'd1));
         d = 64'(lattice_hash(seed, ix + 32'd1, iz + 32'd1));
         top = a * (UNIT_Q16 - wx) + b * wx;
         bot = c * (UNIT_Q16 - wx) + d * wx;
         mix = (top * (UNIT_Q16 - wz) + bot * wz) >> 32;
         if (mix > 64'hFFFF_FFFF)
            mix = 64'hFFFF_FFFF;
         return mix[31:0];
      endfunction

      function void note_point(logic [31:0] seed, logic [31:0] x, logic [31:0] z);
         pending_noise = {pending_noise, noise_at(seed, x, z)};
      endfunction

      function void check_noise(logic [31:0] actual);
         logic [31:0] wanted;
         if (pending_noise.size() == 0) begin
            $display("%0t: noise_value unexpected result, expected none, actual %h",
                     $time, actual);
            errors++;
         end else begin
            wanted = pending_noise.pop_front();
            if (actual !== wanted) begin
               $display("%0t: noise_value mismatch, expected %h, actual %h",
                        $time, wanted, actual);
               errors++;
            end
         end
      endfunction

      function int outstanding();
         return pending_noise.size();
      endfunction
   endclass

   noise_scoreboard board = new();

   always #6 clock = ~clock;

   // transaction monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_point(req_tdata[31:0], req_tdata[63:32], req_tdata[95:64]);
         if (rsp_tvalid && rsp_tready)
            board.check_noise(rsp_tdata);
      end
   end

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_len > 0) begin
         rsp_tready <= 1'b0;
         hold_off_len <= hold_off_len - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // offer one point, idling first at random, and wait for its acceptance
   task automatic send_point(logic [31:0] seed, logic [31:0] x, logic [31:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, x, seed};
      do @(posedge clock); while (!req_tready);
   endtask

   // coordinates biased toward lattice points, full fractions and values near the origin
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return {16'($urandom), 16'h0000};
         2: return {16'($urandom), 16'hFFFF};
         default: return 32'($urandom_range(524288)) - 32'd262144;
      endcase
   endfunction

   task automatic send_random(int count);
      for (int n = 0; n < count; n++)
         send_point($urandom, pick_coord(), pick_coord());
   endtask

   // stop offering and wait until every predicted sample has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase one: sender mostly busy, receiver mostly stalled
      send_idle_pct = 14;
      recv_idle_pct = 86;

      // the origin, lattice points and full fractions; lattice points give corner a alone
      send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_point(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      send_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h0000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'hA5A5_5A5A, 32'h8000_0000, 32'h7FFF_FFFF);
      send_point(32'h5A5A_A5A5, 32'h7FFF_FFFF, 32'h8000_0000);
      // cell at minus one on one or both axes: the upper corner on that axis wraps to zero
      send_point(32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_point(32'h8765_4321, 32'hFFFF_0000, 32'hFFFF_8000);
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      send_point(32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF);
      // fraction extremes: smallest step, half, largest
      send_point(32'hDEAD_BEEF, 32'h0000_0001, 32'h0000_0001);
      send_point(32'hDEAD_BEEF, 32'h0000_8000, 32'h0000_8000);
      send_point(32'hDEAD_BEEF, 32'h0000_FFFF, 32'h0000_FFFF);
      send_point(32'hCAFE_F00D, 32'h0003_FFFF, 32'hFFFD_0001);
      send_point(32'hCAFE_F00D, 32'hFFFC_8000, 32'h0001_0000);
      // all-ones seed near the top of the x axis, then points in the lowest cell and cell one
      send_point(32'hFFFF_FFFF, 32'h7FFF_8000, 32'hFFFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_FFFF, 32'h8000_0001);
      send_point(32'h7FFF_FFFF, 32'h0001_0001, 32'h0001_FFFF);

      send_random(160);
      drain();

      // phase two: sender mostly idle, receiver mostly ready
      send_idle_pct = 86;
      recv_idle_pct = 14;
      send_random(160);
      drain();

      // phase three: no idling, plus a long receiver hold-off so the pipe
      // fills and req_tready drops while points keep coming
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_len <= 300;
      @(posedge clock);
      send_random(180);
      drain();

      repeat (TAIL_WAIT) @(posedge clock);
      if (board.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
